### hdl/bvc_pkg.sv
package bvc_pkg;

  localparam int unsigned NumProc      = 32;
  localparam int unsigned CacheEntries = 4096;
  localparam int unsigned BatchMax     = 1024;
  localparam int unsigned RoundsMax    = 8;

  localparam int unsigned ProcW   = $clog2(NumProc);
  localparam int unsigned SlotW   = $clog2(CacheEntries);
  localparam int unsigned EntAw   = ProcW + SlotW;
  localparam int unsigned PendAw  = $clog2(BatchMax);
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 13;

  localparam logic [CfgIdxW-1:0] RegProcCount = 8'd0;
  localparam logic [CfgIdxW-1:0] RegCacheCap  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegBatchSize = 8'd2;
  localparam logic [CfgIdxW-1:0] RegRounds    = 8'd3;

  typedef struct packed {
    logic [5:0]  nproc;
    logic [12:0] cap;
    logic [10:0] bsz;
    logic [3:0]  rnd;
  } cfg_t;

endpackage

### hdl/batched_vertex_cache_simulator_top.sv
// Batched vertex cache simulator with one least-recently-used cache per processor.
// Input words carry a vertex index and a last-of-stream flag; each one gives
// exactly one output word with the hit flag, the serving processor and the
// saturating hit and miss totals. Both channels use valid and stall.
// Configuration words are taken at any time the block is idle; ready is always high.
// An item first walks the serving cache's entry memory up to its highest slot
// ever filled, one slot a cycle, then on a miss walks the pending list of the
// batch, one entry a cycle.
// The item that closes a batch also runs eviction when the pending entries would
// overflow the cache: 32 counting passes over the cache to find the stamp threshold
// and one pass that evicts, then insertion, which reads and then writes each slot visited.
// The output word sits in a register; the next input word is taken while it
// waits, but a further result waits while the receiver stalls.
// Reset, and the word marked last of stream, empty every cache at once by
// clearing the per-processor fill marks; no clearing pass is needed.
module batched_vertex_cache_simulator_top import bvc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        vertex_index_i,
  input  logic               last_of_stream_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [4:0]         processor_o,
  output logic [31:0]        hit_total_o,
  output logic [31:0]        miss_total_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  typedef enum logic [10:0] {
    StIdle   = 11'b000_0000_0001,
    StLookup = 11'b000_0000_0010,
    StPdup   = 11'b000_0000_0100,
    StResp   = 11'b000_0000_1000,
    StClose  = 11'b000_0001_0000,
    StSel    = 11'b000_0010_0000,
    StEvict  = 11'b000_0100_0000,
    StPrep   = 11'b000_1000_0000,
    StInsRd  = 11'b001_0000_0000,
    StInsWr  = 11'b010_0000_0000,
    StFin    = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] stamp;
    logic [31:0] tag;
  } entry_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] tag;
  } pend_t;

  cfg_t cfg;

  bvc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  state_e state_q, state_d;

  logic [31:0]      v_q;
  logic             last_q;
  logic [ProcW-1:0] p_q;
  logic             hit_q;
  logic [ProcW-1:0] cur_q;
  logic [2:0]       round_q;
  logic [9:0]       boff_q;
  logic [31:0]      pos_q;
  logic [31:0]      hcnt_q;
  logic [31:0]      mcnt_q;
  logic [10:0]      pcnt_q;
  logic [12:0]      occ_q [NumProc];
  logic [12:0]      hwm_q [NumProc];

  logic [12:0]      scan_q;
  logic             rd_vld_q;
  logic [SlotW-1:0] rd_slot_q;
  logic [10:0]      pscan_q;
  logic             pd_vld_q;

  logic [12:0]      cnt_q;
  logic [12:0]      kk_q;
  logic [31:0]      prefix_q;
  logic [31:0]      bitsel_q;
  logic [31:0]      mask_q;
  logic [12:0]      eqc_q;
  logic [12:0]      evict_q;
  logic [12:0]      left_q;
  logic [10:0]      ins_q;
  logic [10:0]      ins_k_q;
  logic [SlotW-1:0] ins_s_q;

  logic             out_valid_q;
  logic             out_hit_q;
  logic [4:0]       out_proc_q;
  logic [31:0]      out_htot_q;
  logic [31:0]      out_mtot_q;

  entry_t ent_mem [NumProc*CacheEntries];
  entry_t ent_rdata_q;
  pend_t  pend_mem [BatchMax];
  pend_t  pend_rdata_q;

  logic [12:0]      hwm_cur, occ_cur;
  logic             scan_st, scan_issue, scan_done;
  logic             ent_re, ent_we;
  logic [EntAw-1:0] ent_raddr, ent_waddr;
  entry_t           ent_wdata;
  logic             pend_issue, pend_re, pend_we, pscan_done;
  logic [PendAw-1:0] pend_raddr;
  logic             match, dup, ev_lt, ev_eq, ev_hit, sel_cnt, slot_free;
  logic [ProcW-1:0] p_new;
  logic [31:0]      hcnt_inc, mcnt_inc;
  logic             res_go;
  logic [13:0]      sum14, need14;
  logic [12:0]      evict_n, left_n, room_n;
  logic [10:0]      ins_n;

  assign hwm_cur = hwm_q[p_q];
  assign occ_cur = occ_q[p_q];

  assign scan_st    = (state_q == StLookup) || (state_q == StSel) || (state_q == StEvict);
  assign scan_issue = scan_st && (scan_q < hwm_cur);
  assign scan_done  = (scan_q >= hwm_cur) && !rd_vld_q;
  assign ent_re     = scan_issue || (state_q == StInsRd);
  assign ent_raddr  = (state_q == StInsRd) ? {p_q, ins_s_q} : {p_q, scan_q[SlotW-1:0]};

  assign pend_issue = (state_q == StPdup) && (pscan_q < pcnt_q);
  assign pend_re    = pend_issue || (state_q == StInsRd);
  assign pend_raddr = (state_q == StInsRd) ? ins_k_q[PendAw-1:0] : pscan_q[PendAw-1:0];
  assign pscan_done = (pscan_q >= pcnt_q) && !pd_vld_q;

  assign match   = rd_vld_q && ent_rdata_q.valid && (ent_rdata_q.tag == v_q);
  assign dup     = pd_vld_q && (pend_rdata_q.tag == v_q);
  assign ev_lt   = ent_rdata_q.stamp < prefix_q;
  assign ev_eq   = ent_rdata_q.stamp == prefix_q;
  assign ev_hit  = rd_vld_q && ent_rdata_q.valid && (ev_lt || (ev_eq && (eqc_q < kk_q)));
  assign sel_cnt = rd_vld_q && ent_rdata_q.valid &&
                   (((ent_rdata_q.stamp ^ prefix_q) & mask_q) == 32'd0) &&
                   ((ent_rdata_q.stamp & bitsel_q) == 32'd0);
  assign slot_free = !(ent_rdata_q.valid && ({1'b0, ins_s_q} < hwm_cur));

  assign pend_we = (state_q == StPdup) && pscan_done && (pcnt_q < 11'(BatchMax));

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = {p_q, rd_slot_q};
    ent_wdata = '{valid: 1'b0, stamp: ent_rdata_q.stamp, tag: ent_rdata_q.tag};
    case (state_q)
      StLookup: begin
        if (match) begin
          ent_we    = 1'b1;
          ent_wdata = '{valid: 1'b1, stamp: pos_q, tag: v_q};
        end
      end
      StEvict: begin
        ent_we = ev_hit;
      end
      StInsWr: begin
        ent_we    = slot_free;
        ent_waddr = {p_q, ins_s_q};
        ent_wdata = '{valid: 1'b1, stamp: pend_rdata_q.stamp, tag: pend_rdata_q.tag};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_q <= ent_mem[ent_raddr];
    end
    if (pend_we) begin
      pend_mem[pcnt_q[PendAw-1:0]] <= '{stamp: pos_q, tag: v_q};
    end
    if (pend_re) begin
      pend_rdata_q <= pend_mem[pend_raddr];
    end
  end

  assign p_new    = ({1'b0, cur_q} >= cfg.nproc) ? '0 : cur_q;
  assign hcnt_inc = hcnt_q + {31'd0, (hcnt_q != 32'hFFFF_FFFF)};
  assign mcnt_inc = mcnt_q + {31'd0, (mcnt_q != 32'hFFFF_FFFF)};
  assign res_go   = !out_valid_q || !out_stall_i;

  assign sum14   = {1'b0, occ_cur} + {3'd0, pcnt_q};
  assign need14  = (sum14 > {1'b0, cfg.cap}) ? (sum14 - {1'b0, cfg.cap}) : 14'd0;
  assign evict_n = (need14 > {1'b0, occ_cur}) ? occ_cur : need14[12:0];
  assign left_n  = occ_cur - evict_q;
  assign room_n  = cfg.cap - left_n;
  assign ins_n   = ({2'd0, pcnt_q} > room_n) ? room_n[10:0] : pcnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_valid_i) state_d = StLookup;
      StLookup: begin
        if (match) begin
          state_d = StResp;
        end else if (scan_done) begin
          state_d = StPdup;
        end
      end
      StPdup:   if (dup || pscan_done) state_d = StResp;
      StResp: begin
        if (res_go) begin
          if (last_q || ({1'b0, boff_q} + 11'd1 < cfg.bsz)) begin
            state_d = StIdle;
          end else begin
            state_d = StClose;
          end
        end
      end
      StClose:  state_d = (evict_n == 13'd0) ? StPrep : StSel;
      StSel:    if (scan_done && bitsel_q[0]) state_d = StEvict;
      StEvict:  if (scan_done) state_d = StPrep;
      StPrep:   state_d = (ins_n == 11'd0) ? StFin : StInsRd;
      StInsRd:  state_d = StInsWr;
      StInsWr: begin
        if (slot_free && (ins_k_q + 11'd1 == ins_q)) begin
          state_d = StFin;
        end else begin
          state_d = StInsRd;
        end
      end
      StFin:    state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      round_q     <= '0;
      boff_q      <= '0;
      pos_q       <= '0;
      hcnt_q      <= '0;
      mcnt_q      <= '0;
      pcnt_q      <= '0;
      rd_vld_q    <= 1'b0;
      pd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumProc; i++) begin
        occ_q[i] <= '0;
        hwm_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_issue;
      pd_vld_q <= pend_issue;
      if (out_valid_q && !out_stall_i && (state_q != StResp)) begin
        out_valid_q <= 1'b0;
      end
      if (scan_issue) begin
        scan_q <= scan_q + 13'd1;
      end
      if (pend_issue) begin
        pscan_q <= pscan_q + 11'd1;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            v_q    <= vertex_index_i;
            last_q <= last_of_stream_i;
            p_q    <= p_new;
            cur_q  <= p_new;
            hit_q  <= 1'b0;
            scan_q <= '0;
          end
        end
        StLookup: begin
          if (match) begin
            hit_q <= 1'b1;
          end else if (scan_done) begin
            pscan_q <= '0;
          end
        end
        StPdup: begin
          if (!dup && pend_we) begin
            pcnt_q <= pcnt_q + 11'd1;
          end
        end
        StResp: begin
          if (res_go) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_proc_q  <= p_q;
            out_htot_q  <= hit_q ? hcnt_inc : hcnt_q;
            out_mtot_q  <= hit_q ? mcnt_q : mcnt_inc;
            if (last_q) begin
              cur_q   <= '0;
              round_q <= '0;
              boff_q  <= '0;
              pos_q   <= '0;
              hcnt_q  <= '0;
              mcnt_q  <= '0;
              pcnt_q  <= '0;
              for (int i = 0; i < NumProc; i++) begin
                occ_q[i] <= '0;
                hwm_q[i] <= '0;
              end
            end else begin
              pos_q <= pos_q + 32'd1;
              if (hit_q) begin
                hcnt_q <= hcnt_inc;
              end else begin
                mcnt_q <= mcnt_inc;
              end
              if ({1'b0, boff_q} + 11'd1 < cfg.bsz) begin
                boff_q <= boff_q + 10'd1;
              end
            end
          end
        end
        StClose: begin
          evict_q  <= evict_n;
          kk_q     <= evict_n;
          prefix_q <= '0;
          bitsel_q <= 32'h8000_0000;
          mask_q   <= '0;
          cnt_q    <= '0;
          scan_q   <= '0;
        end
        StSel: begin
          if (scan_done) begin
            if (kk_q > cnt_q) begin
              prefix_q <= prefix_q | bitsel_q;
              kk_q     <= kk_q - cnt_q;
            end
            bitsel_q <= bitsel_q >> 1;
            mask_q   <= mask_q | bitsel_q;
            cnt_q    <= '0;
            scan_q   <= '0;
            eqc_q    <= '0;
          end else if (sel_cnt) begin
            cnt_q <= cnt_q + 13'd1;
          end
        end
        StEvict: begin
          if (ev_hit && ev_eq) begin
            eqc_q <= eqc_q + 13'd1;
          end
        end
        StPrep: begin
          left_q  <= left_n;
          ins_q   <= ins_n;
          ins_k_q <= '0;
          ins_s_q <= '0;
        end
        StInsWr: begin
          ins_s_q <= ins_s_q + 1'b1;
          if (slot_free) begin
            ins_k_q <= ins_k_q + 11'd1;
            if ({1'b0, ins_s_q} >= hwm_cur) begin
              hwm_q[p_q] <= {1'b0, ins_s_q} + 13'd1;
            end
          end
        end
        StFin: begin
          occ_q[p_q] <= left_q + {2'd0, ins_q};
          pcnt_q     <= '0;
          boff_q     <= '0;
          if ({1'b0, round_q} + 4'd1 >= cfg.rnd) begin
            round_q <= '0;
            cur_q   <= ({1'b0, p_q} + 6'd1 >= cfg.nproc) ? '0 : p_q + 1'b1;
          end else begin
            round_q <= round_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= scan_q[SlotW-1:0];
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign processor_o  = out_proc_q;
  assign hit_total_o  = out_htot_q;
  assign miss_total_o = out_mtot_q;

endmodule

### hdl/bvc_cfg.sv
module bvc_cfg import bvc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output cfg_t               cfg_o
);

  logic [5:0]  nproc_q;
  logic [12:0] cap_q;
  logic [10:0] bsz_q;
  logic [3:0]  rnd_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nproc_q <= 6'd28;
      cap_q   <= 13'd4096;
      bsz_q   <= 11'd1024;
      rnd_q   <= 4'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegProcCount: nproc_q <= cfg_data_i[5:0];
        RegCacheCap:  cap_q   <= cfg_data_i[12:0];
        RegBatchSize: bsz_q   <= cfg_data_i[10:0];
        RegRounds:    rnd_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.nproc = (nproc_q == 6'd0) ? 6'd1 :
                  (nproc_q > 6'(NumProc)) ? 6'(NumProc) : nproc_q;
    cfg_o.cap   = (cap_q == 13'd0) ? 13'd1 :
                  (cap_q > 13'(CacheEntries)) ? 13'(CacheEntries) : cap_q;
    cfg_o.bsz   = (bsz_q == 11'd0) ? 11'd1 :
                  (bsz_q > 11'(BatchMax)) ? 11'(BatchMax) : bsz_q;
    cfg_o.rnd   = (rnd_q == 4'd0) ? 4'd1 :
                  (rnd_q > 4'(RoundsMax)) ? 4'(RoundsMax) : rnd_q;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bvc_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [4:0]  processor;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } lookup_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [31:0]        vertex_index_i = '0;
  logic               last_of_stream_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               hit_o;
  logic [4:0]         processor_o;
  logic [31:0]        hit_total_o;
  logic [31:0]        miss_total_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;

  batched_vertex_cache_simulator_top i_dut (.*);

  always #1 clk_i = ~clk_i;

  // Cache model state.
  logic [31:0]  tag_mem   [NumProc*CacheEntries];
  logic [31:0]  stamp_mem [NumProc*CacheEntries];
  bit           valid_mem [NumProc*CacheEntries];
  int unsigned  fill_count [NumProc];
  int unsigned  slot_hwm   [NumProc];
  logic [31:0]  pend_tag   [BatchMax];
  logic [31:0]  pend_stamp [BatchMax];
  int unsigned  pend_cnt, batch_pos, round_cnt, cur_proc;
  logic [31:0]  stream_pos, hits_seen, misses_seen;
  logic [5:0]   reg_nproc = 6'd28;
  logic [12:0]  reg_cap   = 13'd4096;
  logic [10:0]  reg_bsz   = 11'd1024;
  logic [3:0]   reg_rnd   = 4'd3;

  lookup_t     lookups_due [$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void clear_caches();
    for (int p = 0; p < NumProc; p++) begin
      for (int s = 0; s < slot_hwm[p]; s++) valid_mem[p*CacheEntries+s] = 1'b0;
      fill_count[p] = 0;
      slot_hwm[p] = 0;
    end
    pend_cnt = 0; batch_pos = 0; round_cnt = 0; cur_proc = 0;
    stream_pos = '0; hits_seen = '0; misses_seen = '0;
  endfunction

  function automatic void close_batch(int unsigned p, int unsigned cap);
    int unsigned base, best, s;
    bit found;
    base = p * CacheEntries;
    while (fill_count[p] > 0 && fill_count[p] + pend_cnt > cap) begin
      found = 0;
      best = 0;
      for (int i = 0; i < slot_hwm[p]; i++) begin
        if (valid_mem[base+i] && (!found || stamp_mem[base+i] < stamp_mem[base+best])) begin
          best = i;
          found = 1;
        end
      end
      if (!found) begin
        fill_count[p] = 0;
        break;
      end
      valid_mem[base+best] = 1'b0;
      fill_count[p]--;
    end
    s = 0;
    for (int k = 0; k < pend_cnt; k++) begin
      if (fill_count[p] >= cap) break;
      while (s < CacheEntries && valid_mem[base+s]) s++;
      if (s >= CacheEntries) break;
      tag_mem[base+s] = pend_tag[k];
      stamp_mem[base+s] = pend_stamp[k];
      valid_mem[base+s] = 1'b1;
      fill_count[p]++;
      if (s + 1 > slot_hwm[p]) slot_hwm[p] = s + 1;
    end
    pend_cnt = 0;
  endfunction

  function automatic lookup_t predict_lookup(logic [31:0] v, logic last);
    int unsigned nproc, cap, bsz, rnd, p, base;
    bit hit, dup;
    lookup_t r;
    nproc = clampv(reg_nproc, 1, NumProc);
    cap   = clampv(reg_cap, 1, CacheEntries);
    bsz   = clampv(reg_bsz, 1, BatchMax);
    rnd   = clampv(reg_rnd, 1, RoundsMax);
    if (cur_proc >= nproc) cur_proc = 0;
    p = cur_proc;
    base = p * CacheEntries;
    hit = 0;
    for (int s = 0; s < slot_hwm[p]; s++) begin
      if (valid_mem[base+s] && tag_mem[base+s] == v) begin
        stamp_mem[base+s] = stream_pos;
        hit = 1;
        break;
      end
    end
    if (hit) begin
      if (hits_seen != '1) hits_seen++;
    end else begin
      if (misses_seen != '1) misses_seen++;
      dup = 0;
      for (int k = 0; k < pend_cnt; k++) begin
        if (pend_tag[k] == v) begin
          dup = 1;
          break;
        end
      end
      if (!dup && pend_cnt < BatchMax) begin
        pend_tag[pend_cnt] = v;
        pend_stamp[pend_cnt] = stream_pos;
        pend_cnt++;
      end
    end
    r.hit = hit;
    r.processor = p[4:0];
    r.hit_total = hits_seen;
    r.miss_total = misses_seen;
    if (last) begin
      clear_caches();
    end else begin
      stream_pos++;
      batch_pos++;
      if (batch_pos >= bsz) begin
        close_batch(p, cap);
        batch_pos = 0;
        round_cnt++;
        if (round_cnt >= rnd) begin
          round_cnt = 0;
          cur_proc = (p + 1 >= nproc) ? 0 : p + 1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_vertex(logic [31:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_index_i <= v;
    last_of_stream_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    lookups_due.push_back(predict_lookup(v, last));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lookups_due.size() != 0 || in_stall_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegProcCount: reg_nproc = val[5:0];
      RegCacheCap:  reg_cap   = val[12:0];
      RegBatchSize: reg_bsz   = val[10:0];
      RegRounds:    reg_rnd   = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned np, int unsigned cap, int unsigned bsz,
                            int unsigned rnd);
    wait_drain();
    write_reg(RegProcCount, CfgDatW'(np));
    write_reg(RegCacheCap, CfgDatW'(cap));
    write_reg(RegBatchSize, CfgDatW'(bsz));
    write_reg(RegRounds, CfgDatW'(rnd));
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    lookup_t exp_w;
    if (out_valid_o && !out_stall_i) begin
      if (lookups_due.size() == 0) begin
        $display("%0t: unexpected word hit=%0b proc=%0d", $time, hit_o, processor_o);
        errors++;
      end else begin
        exp_w = lookups_due.pop_front();
        if (hit_o !== exp_w.hit) begin
          $display("%0t: hit exp %0b got %0b", $time, exp_w.hit, hit_o);
          errors++;
        end
        if (processor_o !== exp_w.processor) begin
          $display("%0t: processor exp %0d got %0d", $time, exp_w.processor, processor_o);
          errors++;
        end
        if (hit_total_o !== exp_w.hit_total) begin
          $display("%0t: hit_total exp %0d got %0d", $time, exp_w.hit_total, hit_total_o);
          errors++;
        end
        if (miss_total_o !== exp_w.miss_total) begin
          $display("%0t: miss_total exp %0d got %0d", $time, exp_w.miss_total, miss_total_o);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic test_reset_defaults();
    send_vertex(32'h0, 1'b0);
    send_vertex(32'hFFFF_FFFF, 1'b0);
    send_vertex(32'h0, 1'b0);
    send_vertex(32'hAAAA_5555, 1'b0);
    send_vertex(32'h5555_AAAA, 1'b0);
    send_vertex(32'hFFFF_FFFF, 1'b1);
    send_vertex(32'h0, 1'b0);
    send_vertex(32'h0, 1'b1);
  endtask

  task automatic test_register_extremes();
    set_config(0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_vertex(32'(i % 3), 1'b0);
    set_config(63, 8191, 2047, 15);
    for (int i = 0; i < 4; i++) send_vertex(32'(i % 2), i == 3);
    set_config(32, 4096, 1, 8);
    for (int i = 0; i < 10; i++) send_vertex(32'(i % 4), 1'b0);
    set_config(2, 2, 8, 1);
    for (int i = 0; i < 8; i++) send_vertex(32'(i), 1'b0);
    set_config(1, 1, 8, 1);
    for (int i = 0; i < 8; i++) send_vertex(32'(i % 5), i == 7);
  endtask

  task automatic test_random_stream(int unsigned n_items);
    logic [31:0] v;
    for (int i = 0; i < n_items; i++) begin
      if (i % 90 == 0) begin
        case ($urandom_range(3))
          0: set_config($urandom_range(1, 4), $urandom_range(1, 16),
                        $urandom_range(1, 8), $urandom_range(1, 8));
          1: set_config(32, $urandom_range(1, 4), $urandom_range(1, 8), 1);
          2: set_config($urandom_range(1, 3), 1, $urandom_range(1, 4), $urandom_range(1, 2));
          default: set_config($urandom_range(0, 63), $urandom_range(0, 24),
                              $urandom_range(0, 12), $urandom_range(0, 15));
        endcase
      end
      if (i == n_items / 2) wait_drain();
      if ($urandom_range(9) == 0) v = $urandom();
      else v = $urandom_range(0, 15);
      send_vertex(v, $urandom_range(99) == 0);
    end
  endtask

  initial begin
    for (int p = 0; p < NumProc; p++) slot_hwm[p] = CacheEntries;
    clear_caches();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    send_idle_pct = 34; recv_idle_pct = 62;
    test_random_stream(530);
    send_idle_pct = 62; recv_idle_pct = 34;
    test_random_stream(530);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_stream(530);
    wait_drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && lookups_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
hdl/bvc_pkg.sv
hdl/bvc_cfg.sv
hdl/batched_vertex_cache_simulator_top.sv
tb/tb_top.sv
